// ===== design/kms_pkg.sv =====
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types, operation codes and defaults for the keyboard matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

   // Default matrix sizes
   localparam int MAIN_ROWS_DEF  = 8;
   localparam int EXTRA_ROWS_DEF = 4;

   // Column counts of the two matrices
   localparam int MAIN_COLS  = 8;
   localparam int EXTRA_COLS = 4;

   // Extra matrix keeps only the low nibble of its select and read data
   localparam logic [EXTRA_COLS-1:0] NIBBLE_MASK = 4'hF;

   // Operation codes
   localparam logic [1:0] OP_KEY_EVENT  = 2'd0;
   localparam logic [1:0] OP_MAIN_SEL   = 2'd1;
   localparam logic [1:0] OP_EXTRA_SEL  = 2'd2;

   // Request transaction
   typedef struct packed {
      logic [1:0] op;
      logic       in_extra;
      logic [2:0] key_row;
      logic [2:0] key_col;
      logic       pressed;
      logic [7:0] mask_value;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [MAIN_COLS-1:0]  main_data;
      logic [EXTRA_COLS-1:0] extra_data;
   } rsp_type;

endpackage

// ===== design/keyboard_matrix_scanner_core.sv =====
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner_core
// Main and extra key matrices with active-low row selects and read ports.
// ----------------------------------------------------------------------------
// An accepted request is held in the request register; the response strobe and
// data are registered from it in the response register, where the receiver takes them.
// Throughput: one transaction per cycle; busy never rises, since the key
// update and the row OR tree fit between the request and response registers.
// The receiver cannot stall; each response is shown for exactly one cycle.
// Reset (synchronous) releases all keys, deselects all rows, drops pending work.
module keyboard_matrix_scanner_core
   import kms_pkg::*;
#(
   parameter int MAIN_ROWS  = MAIN_ROWS_DEF,
   parameter int EXTRA_ROWS = EXTRA_ROWS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Extra rows that a 4-bit select can reach
   localparam int EXTRA_SCAN = (EXTRA_ROWS < EXTRA_COLS) ? EXTRA_ROWS : EXTRA_COLS;

   // Request stage
   logic    req_valid_ff;
   req_type req_ff;

   // Key and select state
   logic [MAIN_COLS-1:0]  main_keys_ff  [MAIN_ROWS];
   logic [MAIN_COLS-1:0]  main_keys_in  [MAIN_ROWS];
   logic [EXTRA_COLS-1:0] extra_keys_ff [EXTRA_ROWS];
   logic [EXTRA_COLS-1:0] extra_keys_in [EXTRA_ROWS];
   logic [7:0]            main_sel_ff;
   logic [7:0]            main_sel_in;
   logic [EXTRA_COLS-1:0] extra_sel_ff;
   logic [EXTRA_COLS-1:0] extra_sel_in;

   // Response stage
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic [MAIN_COLS-1:0]  main_acc;
   logic [EXTRA_COLS-1:0] extra_acc;

   assign busy = 1'b0;

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // Apply the operation to produce next state
   always_comb begin
      main_keys_in  = main_keys_ff;
      extra_keys_in = extra_keys_ff;
      main_sel_in   = main_sel_ff;
      extra_sel_in  = extra_sel_ff;
      if (req_valid_ff) begin
         case (req_ff.op)
            OP_KEY_EVENT: begin
               if (req_ff.in_extra) begin
                  for (int r = 0; r < EXTRA_ROWS; r++) begin
                     if (req_ff.key_row == 3'(r) && !req_ff.key_col[2]) begin
                        extra_keys_in[r][req_ff.key_col[1:0]] = req_ff.pressed;
                     end
                  end
               end else begin
                  for (int r = 0; r < MAIN_ROWS; r++) begin
                     if (req_ff.key_row == 3'(r)) begin
                        main_keys_in[r][req_ff.key_col] = req_ff.pressed;
                     end
                  end
               end
            end
            OP_MAIN_SEL: begin
               main_sel_in = ~req_ff.mask_value;
            end
            OP_EXTRA_SEL: begin
               extra_sel_in = ~req_ff.mask_value[EXTRA_COLS-1:0] & NIBBLE_MASK;
            end
            default: begin
            end
         endcase
      end
   end

   // OR the selected rows of the updated state
   always_comb begin
      main_acc  = '0;
      extra_acc = '0;
      for (int r = 0; r < MAIN_ROWS; r++) begin
         if (main_sel_in[r]) begin
            main_acc = main_acc | main_keys_in[r];
         end
      end
      for (int r = 0; r < EXTRA_SCAN; r++) begin
         if (extra_sel_in[r]) begin
            extra_acc = extra_acc | extra_keys_in[r];
         end
      end
      rsp_in.main_data  = ~main_acc;
      rsp_in.extra_data = ~extra_acc & NIBBLE_MASK;
   end

   // Commit state and register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAIN_ROWS; r++) begin
            main_keys_ff[r] <= '0;
         end
         for (int r = 0; r < EXTRA_ROWS; r++) begin
            extra_keys_ff[r] <= '0;
         end
         main_sel_ff  <= '0;
         extra_sel_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         main_keys_ff  <= main_keys_in;
         extra_keys_ff <= extra_keys_in;
         main_sel_ff   <= main_sel_in;
         extra_sel_ff  <= extra_sel_in;
         rsp_valid_ff  <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks keyboard_matrix_scanner_core against a behavioral scan model.
// Key events, row select writes and plain reads go in from a queue, with random sender
// gaps in several phases. Every response is compared with the model's read
// byte and read nibble, in order.
// ----------------------------------------------------------------------------
module testbench;
   import kms_pkg::*;

   // Operation code that the block decodes as a plain read
   localparam logic [1:0] OP_READ_ONLY = 2'd3;

   localparam int RANDOM_PER_PHASE = 380;
   localparam int DRAIN_CYCLES     = 6;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Scan state tracked by the predictor
   logic [MAIN_COLS-1:0]  main_keys [MAIN_ROWS_DEF];
   logic [EXTRA_COLS-1:0] extra_keys [EXTRA_ROWS_DEF];
   logic [MAIN_COLS-1:0]  main_rows_selected = '0;
   logic [EXTRA_COLS-1:0] extra_rows_selected = '0;

   req_type pending_requests [$];
   rsp_type expected_reads [$];
   int      sender_idle_pct = 0;
   int      mismatches = 0;

   keyboard_matrix_scanner_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one transaction to the scan state and return the read values
   function automatic rsp_type scan_transaction(req_type req);
      rsp_type                 read;
      logic [MAIN_COLS-1:0]    main_or;
      logic [EXTRA_COLS-1:0]   extra_or;
      main_or = '0;
      extra_or = '0;
      case (req.op)
         OP_KEY_EVENT: begin
            if (req.in_extra) begin
               if (req.key_row < EXTRA_ROWS_DEF && req.key_col < EXTRA_COLS)
                  extra_keys[req.key_row[1:0]][req.key_col[1:0]] = req.pressed;
            end else begin
               if (req.key_row < MAIN_ROWS_DEF)
                  main_keys[req.key_row][req.key_col] = req.pressed;
            end
         end
         OP_MAIN_SEL:  main_rows_selected = ~req.mask_value;
         OP_EXTRA_SEL: extra_rows_selected = ~req.mask_value[EXTRA_COLS-1:0] & NIBBLE_MASK;
         default: ;
      endcase
      for (int r = 0; r < MAIN_ROWS_DEF; r++)
         if (main_rows_selected[r]) main_or |= main_keys[r];
      for (int r = 0; r < EXTRA_ROWS_DEF; r++)
         if (extra_rows_selected[r]) extra_or |= extra_keys[r];
      read.main_data = ~main_or;
      read.extra_data = ~extra_or & NIBBLE_MASK;
      return read;
   endfunction

   function automatic req_type make_request(logic [1:0] op, int in_extra,
                                            int row, int col,
                                            int pressed, logic [7:0] mask);
      req_type req;
      req.op = op;
      req.in_extra = 1'(in_extra);
      req.key_row = 3'(row);
      req.key_col = 3'(col);
      req.pressed = 1'(pressed);
      req.mask_value = mask;
      return req;
   endfunction

   task automatic note_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   // Drive transactions; predict each one at the edge that accepts it
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_reads.push_back(scan_transaction(req_data));
         if (start && busy) begin
            // hold the current transaction until it is taken
         end else if (pending_requests.size() > 0 &&
                      $urandom_range(99) >= sender_idle_pct) begin
            start <= 1'b1;
            req_data <= pending_requests.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Compare every response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_reads.size() == 0) begin
            note_mismatch("unexpected response", 0, int'(rsp_data));
         end else begin
            want = expected_reads.pop_front();
            if (rsp_data.main_data !== want.main_data)
               note_mismatch("main_data", int'(want.main_data), int'(rsp_data.main_data));
            if (rsp_data.extra_data !== want.extra_data)
               note_mismatch("extra_data", int'(want.extra_data),
                             int'(rsp_data.extra_data));
         end
      end
   end

   // Stimulus: directed sequence, then random phases with varying sender gaps
   initial begin
      int pick;
      for (int r = 0; r < MAIN_ROWS_DEF; r++) main_keys[r] = '0;
      for (int r = 0; r < EXTRA_ROWS_DEF; r++) extra_keys[r] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reads at reset, select extremes, corner keys, ignored positions
      pending_requests.push_back(make_request(OP_READ_ONLY, 0, 0, 0, 0, 8'h00));
      pending_requests.push_back(make_request(OP_MAIN_SEL, 0, 0, 0, 0, 8'h00));
      pending_requests.push_back(make_request(OP_EXTRA_SEL, 0, 0, 0, 0, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 0, 0, 0, 1, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 0, 7, 7, 1, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 0, 3, 5, 1, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 1, 0, 0, 1, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 1, 3, 3, 1, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 1, 4, 1, 1, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 1, 7, 7, 1, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 1, 1, 4, 1, 8'h00));
      pending_requests.push_back(make_request(OP_READ_ONLY, 1, 7, 7, 1, 8'hFF));
      pending_requests.push_back(make_request(OP_MAIN_SEL, 0, 0, 0, 0, 8'hFE));
      pending_requests.push_back(make_request(OP_MAIN_SEL, 0, 0, 0, 0, 8'h7F));
      pending_requests.push_back(make_request(OP_MAIN_SEL, 1, 7, 7, 1, 8'hFF));
      pending_requests.push_back(make_request(OP_EXTRA_SEL, 0, 0, 0, 0, 8'hF0));
      pending_requests.push_back(make_request(OP_EXTRA_SEL, 0, 0, 0, 0, 8'hFE));
      pending_requests.push_back(make_request(OP_EXTRA_SEL, 0, 0, 0, 0, 8'hF7));
      pending_requests.push_back(make_request(OP_EXTRA_SEL, 1, 7, 7, 1, 8'hFF));
      pending_requests.push_back(make_request(OP_MAIN_SEL, 0, 0, 0, 0, 8'h00));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 0, 0, 0, 0, 8'hFF));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 0, 7, 7, 0, 8'hFF));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 1, 3, 3, 0, 8'hFF));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 0, 3, 5, 0, 8'hFF));
      pending_requests.push_back(make_request(OP_KEY_EVENT, 1, 0, 0, 0, 8'hFF));

      // Phases: no gaps, heavy gaps, light gaps, no gaps again
      for (int phase = 0; phase < 4; phase++) begin
         // pause the sender until every prediction has been answered
         while (pending_requests.size() > 0 || start || expected_reads.size() > 0)
            @(negedge clock);
         case (phase)
            1: sender_idle_pct = 63;
            2: sender_idle_pct = 25;
            default: sender_idle_pct = 0;
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // half key events, the rest select writes and plain reads
            pick = $urandom_range(99);
            pending_requests.push_back(make_request(
               pick < 50 ? OP_KEY_EVENT : pick < 70 ? OP_MAIN_SEL :
               pick < 90 ? OP_EXTRA_SEL : OP_READ_ONLY,
               $urandom_range(1), $urandom_range(7), $urandom_range(7),
               $urandom_range(1), 8'($urandom_range(255))));
         end
      end

      // Drain and let the pipeline settle
      while (pending_requests.size() > 0 || start || expected_reads.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_reads.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
